@@ sv/shdf_pkg.sv @@
package shdf_pkg;

   localparam int unsigned APB_ADDR_WIDTH = 4;
   localparam int unsigned APB_DATA_WIDTH = 32;

   localparam logic [7:0]  SYNC_RESET    = 8'hC0;
   localparam logic [7:0]  VERSION_RESET = 8'h00;
   localparam logic [15:0] SEED_RESET    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'h1021;

   typedef enum logic [1:0] {
      REG_SYNC    = 2'd0,
      REG_VERSION = 2'd1,
      REG_SEED    = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_GOOD  = 2'd1,
      KIND_BAD   = 2'd2,
      KIND_TRUNC = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      HP_HUNT    = 3'd0,
      HP_VERSION = 3'd1,
      HP_COUNTER = 3'd2,
      HP_TYPE    = 3'd3,
      HP_LENGTH  = 3'd4,
      HP_CRC_HI  = 3'd5,
      HP_CRC_LO  = 3'd6
   } hpos_type;

   typedef struct packed {
      logic [7:0]  sync_value;
      logic [7:0]  version_value;
      logic [15:0] crc_seed;
   } cfg_type;

   typedef struct packed {
      kind_type   out_kind;
      logic [7:0] out_byte;
      logic [7:0] msg_type;
      logic [7:0] frame_len;
      logic [7:0] seq_gap;
   } result_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

@@ sv/shdf_req_if.sv @@
interface shdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       burst_end;

   modport source (output valid, output rx_byte, output burst_end, input ready);
   modport sink (input valid, input rx_byte, input burst_end, output ready);
endinterface

@@ sv/shdf_rsp_if.sv @@
interface shdf_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] out_kind;
   logic [7:0] out_byte;
   logic [7:0] msg_type;
   logic [7:0] frame_len;
   logic [7:0] seq_gap;

   modport source (output valid, output out_kind, output out_byte, output msg_type,
                   output frame_len, output seq_gap, input ready);
   modport sink (input valid, input out_kind, input out_byte, input msg_type,
                 input frame_len, input seq_gap, output ready);
endinterface

@@ sv/shdf_csr.sv @@
module shdf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [shdf_pkg::APB_ADDR_WIDTH-1:0] paddr,
   input  logic [shdf_pkg::APB_DATA_WIDTH-1:0] pwdata,
   output logic [shdf_pkg::APB_DATA_WIDTH-1:0] prdata,
   output logic                                pready,
   output shdf_pkg::cfg_type                   cfg
);
   import shdf_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       write_en;
   logic [1:0] reg_sel;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite;
   assign reg_sel  = paddr[3:2];
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_sel)
            REG_SYNC:    cfg_in.sync_value    = pwdata[7:0];
            REG_VERSION: cfg_in.version_value = pwdata[7:0];
            REG_SEED:    cfg_in.crc_seed      = pwdata[15:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_SYNC:    prdata = {{(APB_DATA_WIDTH-8){1'b0}}, cfg_ff.sync_value};
         REG_VERSION: prdata = {{(APB_DATA_WIDTH-8){1'b0}}, cfg_ff.version_value};
         REG_SEED:    prdata = {{(APB_DATA_WIDTH-16){1'b0}}, cfg_ff.crc_seed};
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_value    <= SYNC_RESET;
         cfg_ff.version_value <= VERSION_RESET;
         cfg_ff.crc_seed      <= SEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sv/shdf_core.sv @@
module shdf_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [7:0]           rx_byte,
   input  logic                 burst_end,
   input  shdf_pkg::cfg_type    cfg,
   output logic                 res_valid,
   output shdf_pkg::result_type res
);
   import shdf_pkg::*;

   hpos_type    header_pos_ff, header_pos_in;
   logic        in_payload_ff, in_payload_in;
   logic [7:0]  rx_counter_ff, rx_counter_in;
   logic [7:0]  rx_type_ff, rx_type_in;
   logic [7:0]  rx_length_ff, rx_length_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [15:0] run_crc_ff, run_crc_in;
   logic [7:0]  expected_ff, expected_in;

   logic        finish;
   logic        pass_byte;
   logic        truncate;
   logic [7:0]  finish_byte;
   logic [7:0]  gap;

   assign gap = rx_counter_ff - (expected_ff + 8'd1);

   always_comb begin
      header_pos_in = header_pos_ff;
      in_payload_in = in_payload_ff;
      rx_counter_in = rx_counter_ff;
      rx_type_in    = rx_type_ff;
      rx_length_in  = rx_length_ff;
      rx_crc_in     = rx_crc_ff;
      bytes_left_in = bytes_left_ff;
      run_crc_in    = run_crc_ff;
      expected_in   = expected_ff;
      finish        = 1'b0;
      pass_byte     = 1'b0;
      truncate      = 1'b0;
      finish_byte   = 8'd0;

      if (in_payload_ff) begin
         run_crc_in    = crc16_byte(run_crc_ff, rx_byte);
         bytes_left_in = bytes_left_ff - 8'd1;
         if (bytes_left_in == 8'd0) begin
            finish      = 1'b1;
            finish_byte = rx_byte;
         end else begin
            pass_byte = 1'b1;
         end
      end else begin
         case (header_pos_ff)
            HP_VERSION: begin
               if (rx_byte == cfg.version_value) begin
                  header_pos_in = HP_COUNTER;
               end else if (rx_byte == cfg.sync_value) begin
                  header_pos_in = HP_VERSION;
                  rx_counter_in = 8'd0;
                  rx_type_in    = 8'd0;
                  rx_length_in  = 8'd0;
                  rx_crc_in     = 16'd0;
               end else begin
                  header_pos_in = HP_HUNT;
               end
            end
            HP_COUNTER: begin
               rx_counter_in = rx_byte;
               header_pos_in = HP_TYPE;
            end
            HP_TYPE: begin
               rx_type_in    = rx_byte;
               header_pos_in = HP_LENGTH;
            end
            HP_LENGTH: begin
               rx_length_in  = rx_byte;
               header_pos_in = HP_CRC_HI;
            end
            HP_CRC_HI: begin
               rx_crc_in     = {rx_byte, 8'h00};
               header_pos_in = HP_CRC_LO;
            end
            HP_CRC_LO: begin
               rx_crc_in     = {rx_crc_ff[15:8], rx_byte};
               run_crc_in    = cfg.crc_seed;
               header_pos_in = HP_HUNT;
               if (rx_length_ff == 8'd0) begin
                  finish = 1'b1;
               end else begin
                  in_payload_in = 1'b1;
                  bytes_left_in = rx_length_ff;
               end
            end
            default: begin
               header_pos_in = HP_HUNT;
               if (rx_byte == cfg.sync_value) begin
                  header_pos_in = HP_VERSION;
                  rx_counter_in = 8'd0;
                  rx_type_in    = 8'd0;
                  rx_length_in  = 8'd0;
                  rx_crc_in     = 16'd0;
               end
            end
         endcase
      end

      if (finish) begin
         expected_in   = rx_counter_ff;
         in_payload_in = 1'b0;
         header_pos_in = HP_HUNT;
         bytes_left_in = 8'd0;
      end else if (burst_end && (in_payload_in || header_pos_in != HP_HUNT)) begin
         truncate      = 1'b1;
         in_payload_in = 1'b0;
         header_pos_in = HP_HUNT;
         bytes_left_in = 8'd0;
      end
   end

   always_comb begin
      res_valid     = finish || pass_byte || truncate;
      res.msg_type  = rx_type_in;
      res.frame_len = rx_length_in;
      if (finish) begin
         res.out_kind = (run_crc_in == rx_crc_in) ? KIND_GOOD : KIND_BAD;
         res.out_byte = finish_byte;
         res.seq_gap  = gap;
      end else if (truncate) begin
         res.out_kind = KIND_TRUNC;
         res.out_byte = 8'd0;
         res.seq_gap  = 8'd0;
      end else begin
         res.out_kind = KIND_DATA;
         res.out_byte = rx_byte;
         res.seq_gap  = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_pos_ff <= HP_HUNT;
         in_payload_ff <= 1'b0;
         rx_counter_ff <= 8'd0;
         rx_type_ff    <= 8'd0;
         rx_length_ff  <= 8'd0;
         rx_crc_ff     <= 16'd0;
         bytes_left_ff <= 8'd0;
         run_crc_ff    <= 16'd0;
         expected_ff   <= 8'd0;
      end else if (step_en) begin
         header_pos_ff <= header_pos_in;
         in_payload_ff <= in_payload_in;
         rx_counter_ff <= rx_counter_in;
         rx_type_ff    <= rx_type_in;
         rx_length_ff  <= rx_length_in;
         rx_crc_ff     <= rx_crc_in;
         bytes_left_ff <= bytes_left_in;
         run_crc_ff    <= run_crc_in;
         expected_ff   <= expected_in;
      end
   end

   a_payload_not_in_header: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> header_pos_ff == HP_HUNT)
      else $error("payload phase overlaps header parsing");

   a_payload_has_bytes: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> bytes_left_ff != 8'd0)
      else $error("payload phase with no bytes left");

   a_trunc_resets: assert property (@(posedge clock) disable iff (reset)
      (step_en && res_valid && res.out_kind == KIND_TRUNC)
      |=> (!in_payload_ff && header_pos_ff == HP_HUNT))
      else $error("truncation did not restart the hunt");

endmodule

@@ sv/sync_header_frame_deframer_crc16.sv @@
// A request is captured in an input register when it is accepted, and its result, if any,
// is loaded into the output register once that register is empty or being drained.
// One request per cycle is sustained while the result side keeps ready high; the single
// pass through the header step and byte-wide CRC update sets that rate.
// Synchronous active-high reset empties both registers, returns the parser to hunting,
// and loads the register defaults.
module sync_header_frame_deframer_crc16 (
   input  logic                                clock,
   input  logic                                reset,
   shdf_req_if.sink                            req,
   shdf_rsp_if.source                          rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [shdf_pkg::APB_ADDR_WIDTH-1:0] paddr,
   input  logic [shdf_pkg::APB_DATA_WIDTH-1:0] pwdata,
   output logic [shdf_pkg::APB_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);
   import shdf_pkg::*;

   cfg_type    cfg;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type core_res;
   logic       core_res_valid;
   logic       advance;
   logic       req_take;

   shdf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   shdf_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .rx_byte   (in_byte_ff),
      .burst_end (in_end_ff),
      .cfg       (cfg),
      .res_valid (core_res_valid),
      .res       (core_res)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_take  = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = core_res_valid;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req.rx_byte;
         in_end_ff  <= req.burst_end;
      end
      if (advance && core_res_valid) begin
         rsp_ff <= core_res;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_kind  = rsp_ff.out_kind;
   assign rsp.out_byte  = rsp_ff.out_byte;
   assign rsp.msg_type  = rsp_ff.msg_type;
   assign rsp.frame_len = rsp_ff.frame_len;
   assign rsp.seq_gap   = rsp_ff.seq_gap;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!in_valid_ff && !rsp_valid_ff))
      else $error("reset left a request or result pending");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("pending result was overwritten");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req.ready)
      else $error("input register empty but request not accepted");

endmodule

@@ dv/tb_sync_header_frame_deframer_crc16.sv @@
module tb_sync_header_frame_deframer_crc16;
   import shdf_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 4;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [APB_ADDR_WIDTH-1:0] paddr;
   logic [APB_DATA_WIDTH-1:0] pwdata;
   logic [APB_DATA_WIDTH-1:0] prdata;
   logic pready;

   shdf_req_if req ();
   shdf_rsp_if rsp ();

   sync_header_frame_deframer_crc16 u_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req.sink),
      .rsp     (rsp.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Shadow of the block's registers and parser state.
   cfg_type csr_shadow = '{SYNC_RESET, VERSION_RESET, SEED_RESET};
   hpos_type hunt_pos = HP_HUNT;
   bit in_payload = 1'b0;
   logic [7:0] hdr_counter = 8'h00;
   logic [7:0] hdr_type = 8'h00;
   logic [7:0] hdr_length = 8'h00;
   logic [15:0] hdr_crc = 16'h0000;
   logic [7:0] payload_left = 8'h00;
   logic [15:0] payload_crc = 16'h0000;
   logic [7:0] last_counter = 8'h00;

   result_type pending_deframed[$];

   int error_count = 0;
   int cycle_count = 0;
   int frame_bytes_sent = 0;
   bit tx_gaps = 1'b1;
   bit rx_gaps = 1'b1;
   int rsp_hold_left = 0;
   int rsp_stall_left = 0;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_sync_header_frame_deframer_crc16: FAIL");
         $finish;
      end
   end

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      logic fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ data[i];
         c = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic void open_frame();
      hunt_pos = HP_VERSION;
      hdr_counter = 8'h00;
      hdr_type = 8'h00;
      hdr_length = 8'h00;
      hdr_crc = 16'h0000;
   endfunction

   function automatic void close_frame(input logic [7:0] data);
      result_type r;
      r.out_kind = (payload_crc == hdr_crc) ? KIND_GOOD : KIND_BAD;
      r.out_byte = data;
      r.msg_type = hdr_type;
      r.frame_len = hdr_length;
      r.seq_gap = hdr_counter - (last_counter + 8'd1);
      pending_deframed.push_back(r);
      last_counter = hdr_counter;
      in_payload = 1'b0;
      hunt_pos = HP_HUNT;
      payload_left = 8'h00;
   endfunction

   function automatic void deframe_request(input logic [7:0] data, input logic burst_end);
      result_type r;
      bit have;
      have = 1'b0;
      r = '0;
      if (in_payload) begin
         payload_crc = crc_update(payload_crc, data);
         payload_left = payload_left - 8'd1;
         if (payload_left == 8'h00) begin
            close_frame(data);
            return;
         end
         r = '{KIND_DATA, data, hdr_type, hdr_length, 8'h00};
         have = 1'b1;
      end else begin
         case (hunt_pos)
            HP_VERSION: begin
               if (data == csr_shadow.version_value) begin
                  hunt_pos = HP_COUNTER;
               end else if (data == csr_shadow.sync_value) begin
                  open_frame();
               end else begin
                  hunt_pos = HP_HUNT;
               end
            end
            HP_COUNTER: begin
               hdr_counter = data;
               hunt_pos = HP_TYPE;
            end
            HP_TYPE: begin
               hdr_type = data;
               hunt_pos = HP_LENGTH;
            end
            HP_LENGTH: begin
               hdr_length = data;
               hunt_pos = HP_CRC_HI;
            end
            HP_CRC_HI: begin
               hdr_crc = {data, 8'h00};
               hunt_pos = HP_CRC_LO;
            end
            HP_CRC_LO: begin
               hdr_crc[7:0] = data;
               payload_crc = csr_shadow.crc_seed;
               hunt_pos = HP_HUNT;
               if (hdr_length == 8'h00) begin
                  close_frame(8'h00);
                  return;
               end
               in_payload = 1'b1;
               payload_left = hdr_length;
            end
            default: begin
               hunt_pos = HP_HUNT;
               if (data == csr_shadow.sync_value) begin
                  open_frame();
               end
            end
         endcase
      end
      if (burst_end && (in_payload || hunt_pos != HP_HUNT)) begin
         r = '{KIND_TRUNC, 8'h00, hdr_type, hdr_length, 8'h00};
         have = 1'b1;
         in_payload = 1'b0;
         hunt_pos = HP_HUNT;
         payload_left = 8'h00;
      end
      if (have) begin
         pending_deframed.push_back(r);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_deframed.size() == 0) begin
            report_mismatch("result with none expected", 32'(rsp.out_kind), 0);
         end else begin
            want = pending_deframed.pop_front();
            if (rsp.out_kind !== want.out_kind) begin
               report_mismatch("out_kind", 32'(rsp.out_kind), 32'(want.out_kind));
            end
            if (rsp.out_byte !== want.out_byte) begin
               report_mismatch("out_byte", 32'(rsp.out_byte), 32'(want.out_byte));
            end
            if (rsp.msg_type !== want.msg_type) begin
               report_mismatch("msg_type", 32'(rsp.msg_type), 32'(want.msg_type));
            end
            if (rsp.frame_len !== want.frame_len) begin
               report_mismatch("frame_len", 32'(rsp.frame_len), 32'(want.frame_len));
            end
            if (rsp.seq_gap !== want.seq_gap) begin
               report_mismatch("seq_gap", 32'(rsp.seq_gap), 32'(want.seq_gap));
            end
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp.ready <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (rsp_stall_left > 0) begin
         rsp.ready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
         rsp.ready <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 5);
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   task automatic send_request(input logic [7:0] data, input logic burst_end);
      int gap;
      gap = (tx_gaps && $urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
      repeat (gap) begin
         @(negedge clock);
         req.valid <= 1'b0;
      end
      @(negedge clock);
      req.valid <= 1'b1;
      req.rx_byte <= data;
      req.burst_end <= burst_end;
      do @(posedge clock); while (!req.ready);
      deframe_request(data, burst_end);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending_deframed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_SYNC:    csr_shadow.sync_value = value[7:0];
         REG_VERSION: csr_shadow.version_value = value[7:0];
         REG_SEED:    csr_shadow.crc_seed = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== value) begin
         report_mismatch("register read back", prdata, value);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // The burst end flag goes on the byte at index cut_at, and the frame stops there.
   task automatic send_frame(input logic [7:0] counter, input logic [7:0] mtype,
                             input logic [7:0] length, input bit corrupt, input int cut_at);
      logic [7:0] frame_bytes[$];
      logic [7:0] payload[$];
      logic [7:0] data;
      logic [15:0] crc;
      crc = csr_shadow.crc_seed;
      for (int i = 0; i < length; i++) begin
         data = 8'($urandom_range(0, 255));
         payload.push_back(data);
         crc = crc_update(crc, data);
      end
      if (corrupt) begin
         crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      end
      frame_bytes = {csr_shadow.sync_value, csr_shadow.version_value, counter, mtype, length,
                     crc[15:8], crc[7:0]};
      frame_bytes = {frame_bytes, payload};
      for (int i = 0; i < frame_bytes.size(); i++) begin
         send_request(frame_bytes[i], i == cut_at);
         frame_bytes_sent++;
         if (i == cut_at) begin
            break;
         end
      end
   endtask

   task automatic run_random_traffic(input int request_count);
      int target;
      int pick;
      int noise_len;
      logic [7:0] length;
      logic [7:0] counter;
      target = frame_bytes_sent + request_count;
      while (frame_bytes_sent < target) begin
         if ($urandom_range(0, 4) == 0) begin
            noise_len = $urandom_range(1, 4);
            for (int i = 0; i < noise_len; i++) begin
               send_request(8'($urandom_range(0, 255)), i == noise_len - 1);
            end
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               length = 8'($urandom_range(0, 8));
            end else if (pick < 96) begin
               length = 8'($urandom_range(9, 40));
            end else begin
               length = 8'($urandom_range(41, 255));
            end
            counter = ($urandom_range(0, 4) != 0) ? last_counter + 8'd1
                                                  : 8'($urandom_range(0, 255));
            send_frame(counter, 8'($urandom_range(0, 255)), length, $urandom_range(0, 6) == 0,
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, length + 6) : -1);
         end
      end
   endtask

   task automatic test_directed_frames();
      // Empty frame whose counter wraps against the expected one; burst ends on its last byte.
      send_frame(8'hFF, 8'h00, 8'd0, 1'b0, 6);
      // A second sync byte in place of the version restarts the header.
      send_request(csr_shadow.sync_value, 1'b0);
      send_frame(8'h00, 8'hFF, 8'd1, 1'b1, -1);
      // Burst ends inside the header.
      send_frame(8'h7F, 8'h80, 8'd2, 1'b0, 2);
      // Wrong version byte drops back to hunting.
      send_request(csr_shadow.sync_value, 1'b0);
      send_request(8'h55, 1'b0);
      // Burst end while hunting gives nothing.
      send_request(8'h00, 1'b1);
   endtask

   task automatic test_reset_config_traffic();
      run_random_traffic(250);
   endtask

   task automatic test_register_extremes();
      wait_idle();
      write_register(REG_SYNC, 32'h0000_0000);
      write_register(REG_VERSION, 32'h0000_00FF);
      write_register(REG_SEED, 32'h0000_0000);
      run_random_traffic(100);
      wait_idle();
      write_register(REG_SYNC, 32'h0000_00FF);
      write_register(REG_VERSION, 32'h0000_0000);
      write_register(REG_SEED, 32'h0000_FFFF);
      run_random_traffic(100);
      wait_idle();
      write_register(REG_SYNC, $urandom_range(0, 255));
      write_register(REG_VERSION, $urandom_range(0, 255));
      write_register(REG_SEED, $urandom_range(0, 65535));
      run_random_traffic(200);
   endtask

   task automatic test_output_backpressure();
      tx_gaps = 1'b0;
      rsp_hold_left = 150;
      send_frame(last_counter + 8'd1, 8'h3C, 8'd100, 1'b0, -1);
      wait_idle();
      tx_gaps = 1'b1;
   endtask

   task automatic test_unthrottled_traffic();
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      run_random_traffic(250);
   endtask

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.rx_byte = 8'h00;
      req.burst_end = 1'b0;
      rsp.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_reset_config_traffic();
      test_register_extremes();
      test_output_backpressure();
      test_unthrottled_traffic();
      wait_idle();

      if (pending_deframed.size() != 0) begin
         report_mismatch("results never delivered", pending_deframed.size(), 0);
      end
      if (error_count == 0) begin
         $display("tb_sync_header_frame_deframer_crc16: PASS");
      end else begin
         $display("tb_sync_header_frame_deframer_crc16: FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/shdf_pkg.sv
sv/shdf_req_if.sv
sv/shdf_rsp_if.sv
sv/shdf_csr.sv
sv/shdf_core.sv
sv/sync_header_frame_deframer_crc16.sv
dv/tb_sync_header_frame_deframer_crc16.sv
